// File: design/u8d_pkg.sv
// u8d_pkg: shared widths, byte-class constants and structs for the UTF-8 decoder.
// No dependencies; used by the channel interfaces, u8d_dec and the top level.
`timescale 1ns / 1ps
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 22;
  localparam int unsigned RemW  = 2;

  // lead byte classes (mask / match pairs)
  localparam logic [ByteW-1:0] AsciiMask = 8'b1000_0000;
  localparam logic [ByteW-1:0] Lead4Pat  = 8'b1111_0000;
  localparam logic [ByteW-1:0] Lead3Pat  = 8'b1110_0000;
  localparam logic [ByteW-1:0] Lead2Pat  = 8'b1100_0000;

  // payload masks
  localparam logic [ByteW-1:0] Lead4Pay  = 8'b0000_1111;
  localparam logic [ByteW-1:0] Lead3Pay  = 8'b0001_1111;
  localparam logic [ByteW-1:0] SixPay    = 8'b0011_1111;

  localparam int unsigned Lead4Shift = 18;
  localparam int unsigned Lead3Shift = 12;
  localparam int unsigned Lead2Shift = 6;

  localparam logic [RemW-1:0] RemNone  = 2'd0;
  localparam logic [RemW-1:0] RemOne   = 2'd1;
  localparam logic [RemW-1:0] RemTwo   = 2'd2;
  localparam logic [RemW-1:0] RemThree = 2'd3;

  localparam logic [CpW-1:0] BadLeadCp = 22'd1;

  typedef struct packed {
    logic [RemW-1:0] remaining;
    logic [CpW-1:0]  acc;
  } u8d_state_t;

  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] code_point;
    logic           bad_lead;
  } u8d_res_t;

endpackage

// File: design/u8d_if.sv
// u8d_if: valid/ready channel interfaces for the byte input and code point output.
// Depends on u8d_pkg for field widths.
`timescale 1ns / 1ps
interface u8d_byte_if;
  logic                         valid;
  logic                         ready;
  logic [u8d_pkg::ByteW-1:0]    in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_cp_if;
  logic                         valid;
  logic                         ready;
  logic [u8d_pkg::CpW-1:0]      code_point;
  logic                         bad_lead;

  modport source (output valid, output code_point, output bad_lead, input ready);
  modport sink   (input valid, input code_point, input bad_lead, output ready);
endinterface

// File: design/u8d_dec.sv
// u8d_dec: per-byte decode step; next decoder state and optional code point.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
module u8d_dec (
  input  logic [u8d_pkg::ByteW-1:0] byte_i,
  input  u8d_pkg::u8d_state_t       state_i,
  output u8d_pkg::u8d_state_t       state_o,
  output u8d_pkg::u8d_res_t         res_o
);
  import u8d_pkg::*;

  logic [RemW-1:0] rem_dec;
  logic [CpW-1:0]  six_bits;
  logic [CpW-1:0]  acc_or;

  assign rem_dec  = state_i.remaining - RemOne;
  assign six_bits = CpW'(byte_i & SixPay);

  always_comb begin
    case (rem_dec)
      RemNone: acc_or = state_i.acc | six_bits;
      RemOne:  acc_or = state_i.acc | (six_bits << Lead2Shift);
      RemTwo:  acc_or = state_i.acc | (six_bits << Lead3Shift);
      default: acc_or = state_i.acc | (six_bits << Lead4Shift);
    endcase
  end

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    if (state_i.remaining == RemNone) begin
      if ((byte_i & AsciiMask) == '0) begin
        res_o.emit       = 1'b1;
        res_o.code_point = CpW'(byte_i);
      end else if ((byte_i & Lead4Pat) == Lead4Pat) begin
        state_o.remaining = RemThree;
        state_o.acc       = CpW'(byte_i & Lead4Pay) << Lead4Shift;
      end else if ((byte_i & Lead3Pat) == Lead3Pat) begin
        state_o.remaining = RemTwo;
        state_o.acc       = CpW'(byte_i & Lead3Pay) << Lead3Shift;
      end else if ((byte_i & Lead2Pat) == Lead2Pat) begin
        state_o.remaining = RemOne;
        state_o.acc       = CpW'(byte_i & SixPay) << Lead2Shift;
      end else begin
        // stray continuation byte in lead position
        res_o.emit       = 1'b1;
        res_o.code_point = BadLeadCp;
        res_o.bad_lead   = 1'b1;
      end
    end else begin
      state_o.remaining = rem_dec;
      if (rem_dec == RemNone) begin
        res_o.emit       = 1'b1;
        res_o.code_point = acc_or;
        state_o.acc      = '0;
      end else begin
        state_o.acc = acc_or;
      end
    end
  end

endmodule

// File: design/utf8_stream_decoder_top.sv
// utf8_stream_decoder_top: streaming UTF-8 decoder, one byte per transfer.
// Depends on u8d_pkg, u8d_byte_if / u8d_cp_if and u8d_dec.
//
// Usage:
//   byte_i (sink) takes one raw byte per transfer; cp_o (source) gives one
//   decoded code point per transfer, with bad_lead set and code_point 1 when a
//   10xxxxxx byte stood where a lead byte was expected.
//   ASCII bytes, stray continuations and the last byte of a multi-byte
//   sequence each produce one result; lead and middle bytes produce none.
//   Result path: the byte that completes a result sits in the input register,
//   is decoded there, and the result is loaded into the result register
//   that drives cp_o.
//   Throughput: one byte per cycle unless stalled (see Stall), set by the
//   single decode stage between the input register and the result register.
//   Stall: while cp_o holds a result that is not taken, a byte that yields no
//   result still drains; a byte that yields one waits in the input register and
//   byte_i.ready drops once that register is full.
//   Reset: asynchronous, active low; clears both valid flags and the decoder
//   state, so the next byte is taken as a lead byte.
`timescale 1ns / 1ps
module utf8_stream_decoder_top (
  input  logic clk_i,
  input  logic rst_ni,
  u8d_byte_if.sink  byte_i,
  u8d_cp_if.source  cp_o
);
  import u8d_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  u8d_state_t       state_q;
  u8d_state_t       state_d;
  u8d_res_t         res;
  logic             out_valid_q;
  logic [CpW-1:0]   out_cp_q;
  logic             out_bad_q;
  logic             advance;
  logic             in_take;

  u8d_dec u_dec (
    .byte_i  (in_byte_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res)
  );

  // input stage moves on unless its result would overwrite a waiting one
  assign advance = in_valid_q && (!res.emit || !out_valid_q || cp_o.ready);
  assign byte_i.ready = !in_valid_q || advance;
  assign in_take      = byte_i.valid && byte_i.ready;

  assign cp_o.valid      = out_valid_q;
  assign cp_o.code_point = out_cp_q;
  assign cp_o.bad_lead   = out_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && res.emit) begin
        out_valid_q <= 1'b1;
      end else if (cp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= byte_i.in_byte;
    end
    if (advance && res.emit) begin
      out_cp_q  <= res.code_point;
      out_bad_q <= res.bad_lead;
    end
  end

endmodule
